// File: hw/rtl/fnr_pkg.sv
// ----------------------------------------------------------------------------
// Fermi factor package
// Request types, pipeline tag, fixed-point constants and the reciprocal
// table used by the series cells.
// ----------------------------------------------------------------------------
package fnr_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int POS_SHIFT     = 8 + FRACTION_BITS;
    localparam int NEG_SHIFT     = 24 - FRACTION_BITS;

    localparam int SQRT_STEPS   = 32;
    localparam int RATIO_STEPS  = 32;
    localparam int TAYLOR_TERMS = 13;
    localparam int QUO_STEPS    = 34;

    localparam logic [24:0] OUT_MAX    = 25'h1FF_FFFF;
    localparam logic [24:0] ONE_FIXED  = 25'(1) << FRACTION_BITS;
    localparam logic [24:0] ENERGY_MIN = 25'd50;
    localparam logic [18:0] MASS_RESET = 19'd510999;
    localparam logic [27:0] KQ         = 28'd196926905;
    localparam logic [32:0] L2E        = 33'd6196328019;
    localparam logic [31:0] LN2        = 32'd2977044472;
    localparam logic [32:0] ONE_Q32    = {1'b1, 32'b0};

    typedef struct packed {
        logic signed [7:0] charge_number;
        logic [24:0]       kinetic_energy_ev;
    } t_in;

    typedef struct packed {
        logic [24:0] fermi_factor;
        logic        saturated;
    } t_out;

    // Side information that travels with a request down the pipe
    typedef struct packed {
        logic [7:0]  zmag;
        logic        neg;
        logic        zero;
        logic        big;
        logic        gz;
        logic        ovf;
        logic [4:0]  sh;
        logic [25:0] sum_me;
        logic [33:0] a;
    } t_tag;

    // floor(2^35 / k) for the series divisions
    function automatic logic [35:0] recip(input logic [3:0] k);
        logic [35:0] m;
        case (k)
            4'd1:    m = 36'd34359738368;
            4'd2:    m = 36'd17179869184;
            4'd3:    m = 36'd11453246122;
            4'd4:    m = 36'd8589934592;
            4'd5:    m = 36'd6871947673;
            4'd6:    m = 36'd5726623061;
            4'd7:    m = 36'd4908534052;
            4'd8:    m = 36'd4294967296;
            4'd9:    m = 36'd3817748707;
            4'd10:   m = 36'd3435973836;
            4'd11:   m = 36'd3123612578;
            4'd12:   m = 36'd2863311530;
            4'd13:   m = 36'd2643056797;
            default: m = 36'd0;
        endcase
        return m;
    endfunction

endpackage

// File: hw/rtl/fermi_function_nonrel_approx.sv
// ----------------------------------------------------------------------------
// Nonrelativistic Fermi factor
// Throughput: one request per cycle while the output skid slot is free; the
// square root (32 cells), the w/p divider (32 cells), the series (13 cells of
// 3 stages) and the final divider (34 cells) are all fully pipelined chains.
// Reset: synchronous, active low; clears all valid bits and loads the
// electron mass register with 510999 eV.
// ----------------------------------------------------------------------------
module fermi_function_nonrel_approx (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fnr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output fnr_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [18:0]   i_cfg_data
);

    localparam int SQ_N = fnr_pkg::SQRT_STEPS;
    localparam int RT_N = fnr_pkg::RATIO_STEPS;
    localparam int TY_N = fnr_pkg::TAYLOR_TERMS;
    localparam int QD_N = fnr_pkg::QUO_STEPS;

    logic          w_en;
    logic [18:0]   r_mass;

    // Electron mass register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= fnr_pkg::MASS_RESET;
        end else if (i_cfg_valid) begin
            r_mass <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---------------- input decode ----------------
    logic [7:0]    w_zr;
    logic [24:0]   w_e;
    fnr_pkg::t_tag w_tag0;
    logic          r0_valid;
    logic [24:0]   r0_e;
    fnr_pkg::t_tag r0_tag;

    always_comb begin
        w_zr        = i_in_data.charge_number;
        w_tag0      = '0;
        w_tag0.neg  = w_zr[7];
        w_tag0.zmag = w_zr[7] ? 8'(8'd0 - w_zr) : w_zr;
        w_tag0.zero = (w_zr == 8'd0);
        w_e = (i_in_data.kinetic_energy_ev < fnr_pkg::ENERGY_MIN) ?
              fnr_pkg::ENERGY_MIN : i_in_data.kinetic_energy_ev;
    end

    // ---------------- E*(E+2me) and me+E ----------------
    logic [25:0]   w_e2m;
    logic [50:0]   w_dd;
    fnr_pkg::t_tag w_tag1;
    logic          r1_valid;
    logic [50:0]   r1_dd;
    fnr_pkg::t_tag r1_tag;

    always_comb begin
        w_e2m         = 26'(r0_e) + 26'({r_mass, 1'b0});
        w_dd          = {26'b0, r0_e} * {25'b0, w_e2m};
        w_tag1        = r0_tag;
        w_tag1.sum_me = 26'(r0_e) + 26'(r_mass);
    end

    // ---------------- square root chain ----------------
    logic          sq_valid [0:SQ_N];
    logic [63:0]   sq_rad   [0:SQ_N];
    logic [63:0]   sq_root  [0:SQ_N];
    fnr_pkg::t_tag sq_tag   [0:SQ_N];

    assign sq_valid[0] = r1_valid;
    assign sq_rad[0]   = {1'b0, r1_dd, 12'b0};
    assign sq_root[0]  = '0;
    assign sq_tag[0]   = r1_tag;

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        fnr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bit   (64'd1 << (62 - 2 * j)),
            .i_valid (sq_valid[j]),
            .i_rad   (sq_rad[j]),
            .i_root  (sq_root[j]),
            .i_tag   (sq_tag[j]),
            .o_valid (sq_valid[j+1]),
            .o_rad   (sq_rad[j+1]),
            .o_root  (sq_root[j+1]),
            .o_tag   (sq_tag[j+1])
        );
    end

    // ---------------- w/p divider chain ----------------
    logic          rt_valid [0:RT_N];
    logic [33:0]   rt_rem   [0:RT_N];
    logic [33:0]   rt_num   [0:RT_N];
    logic [33:0]   rt_quo   [0:RT_N];
    logic [32:0]   rt_dvs   [0:RT_N];
    fnr_pkg::t_tag rt_tag   [0:RT_N];

    assign rt_valid[0] = sq_valid[SQ_N];
    assign rt_rem[0]   = {10'b0, sq_tag[SQ_N].sum_me[25:2]};
    assign rt_num[0]   = {sq_tag[SQ_N].sum_me[1:0], 32'b0};
    assign rt_quo[0]   = '0;
    assign rt_dvs[0]   = {1'b0, sq_root[SQ_N][31:0]};
    assign rt_tag[0]   = sq_tag[SQ_N];

    for (genvar j = 0; j < RT_N; j++) begin : g_ratio
        fnr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (rt_valid[j]),
            .i_rem   (rt_rem[j]),
            .i_num   (rt_num[j]),
            .i_quo   (rt_quo[j]),
            .i_dvs   (rt_dvs[j]),
            .i_tag   (rt_tag[j]),
            .o_valid (rt_valid[j+1]),
            .o_rem   (rt_rem[j+1]),
            .o_num   (rt_num[j+1]),
            .o_quo   (rt_quo[j+1]),
            .o_dvs   (rt_dvs[j+1]),
            .o_tag   (rt_tag[j+1])
        );
    end

    // ---------------- t = |Z| * KQ * w/p, exponent split ----------------
    logic [59:0]   w_kq;
    logic [34:0]   w_a;
    logic [62:0]   w_y;
    logic [63:0]   w_r;
    logic [6:0]    w_n;
    fnr_pkg::t_tag w_tag_a, w_tag_y, w_tag_r;

    logic          ru_valid, ra_valid, ry_valid, rr_valid;
    logic [26:0]   ru_u;
    logic [38:0]   ry_y;
    logic [31:0]   rr_r;
    fnr_pkg::t_tag ru_tag, ra_tag, ry_tag, rr_tag;

    always_comb begin
        w_kq       = {32'b0, fnr_pkg::KQ} * {28'b0, rt_quo[RT_N][31:0]};
        w_a        = {27'b0, ru_tag.zmag} * {8'b0, ru_u};
        w_tag_a    = ru_tag;
        w_tag_a.a  = w_a[33:0];
        w_y        = {33'b0, ra_tag.a[29:0]} * {30'b0, fnr_pkg::L2E};
        w_tag_y    = ra_tag;
        w_tag_y.gz = |ra_tag.a[33:30];
        w_n        = ry_y[38:32];
        w_r        = {32'b0, ry_y[31:0]} * {32'b0, fnr_pkg::LN2};
        w_tag_r    = ry_tag;
        w_tag_r.gz = ry_tag.gz | (|w_n[6:5]);
        w_tag_r.sh = w_n[4:0];
    end

    // ---------------- exp(-r) series chain ----------------
    logic          ty_valid [0:TY_N];
    logic [32:0]   ty_term  [0:TY_N];
    logic [32:0]   ty_sum   [0:TY_N];
    logic [31:0]   ty_rate  [0:TY_N];
    fnr_pkg::t_tag ty_tag   [0:TY_N];

    assign ty_valid[0] = rr_valid;
    assign ty_term[0]  = fnr_pkg::ONE_Q32;
    assign ty_sum[0]   = fnr_pkg::ONE_Q32;
    assign ty_rate[0]  = rr_r;
    assign ty_tag[0]   = rr_tag;

    for (genvar j = 0; j < TY_N; j++) begin : g_series
        fnr_taylor_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_k     (4'(j + 1)),
            .i_recip (fnr_pkg::recip(4'(j + 1))),
            .i_odd   (1'((j + 1) % 2)),
            .i_valid (ty_valid[j]),
            .i_term  (ty_term[j]),
            .i_sum   (ty_sum[j]),
            .i_rate  (ty_rate[j]),
            .i_tag   (ty_tag[j]),
            .o_valid (ty_valid[j+1]),
            .o_term  (ty_term[j+1]),
            .o_sum   (ty_sum[j+1]),
            .o_rate  (ty_rate[j+1]),
            .o_tag   (ty_tag[j+1])
        );
    end

    // ---------------- g, denominator and numerator ----------------
    logic [32:0]   w_g, w_den;
    logic [62:0]   w_num;
    fnr_pkg::t_tag w_tag_n;
    logic          rg_valid, rn_valid;
    logic [32:0]   rg_g, rg_den, rn_dvs;
    logic [62:0]   rn_num;
    fnr_pkg::t_tag rg_tag, rn_tag;

    always_comb begin
        w_g   = ty_tag[TY_N].gz ? 33'd0 : (ty_sum[TY_N] >> ty_tag[TY_N].sh);
        w_den = fnr_pkg::ONE_Q32 - w_g;
        if (w_den == 33'd0) begin
            w_den = 33'd1;
        end
        if (rg_tag.zero) begin
            w_num = '0;
        end else if (rg_tag.neg) begin
            w_num = {33'b0, rg_tag.a[29:0]} * {30'b0, rg_g};
        end else begin
            w_num = 63'(rg_tag.a[29:0]) << fnr_pkg::POS_SHIFT;
        end
        w_tag_n     = rg_tag;
        w_tag_n.big = !rg_tag.neg && (|rg_tag.a[33:30]);
    end

    // ---------------- final divider chain ----------------
    logic          qd_valid [0:QD_N];
    logic [33:0]   qd_rem   [0:QD_N];
    logic [33:0]   qd_num   [0:QD_N];
    logic [33:0]   qd_quo   [0:QD_N];
    logic [32:0]   qd_dvs   [0:QD_N];
    fnr_pkg::t_tag qd_tag   [0:QD_N];
    fnr_pkg::t_tag w_qd_tag0;

    // Flag quotients that do not fit the chain
    always_comb begin
        w_qd_tag0     = rn_tag;
        w_qd_tag0.ovf = ({4'b0, rn_num[62:34]} >= rn_dvs);
    end

    assign qd_tag[0]   = w_qd_tag0;
    assign qd_valid[0] = rn_valid;
    assign qd_rem[0]   = {5'b0, rn_num[62:34]};
    assign qd_num[0]   = rn_num[33:0];
    assign qd_quo[0]   = '0;
    assign qd_dvs[0]   = rn_dvs;

    for (genvar j = 0; j < QD_N; j++) begin : g_quot
        fnr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (qd_valid[j]),
            .i_rem   (qd_rem[j]),
            .i_num   (qd_num[j]),
            .i_quo   (qd_quo[j]),
            .i_dvs   (qd_dvs[j]),
            .i_tag   (qd_tag[j]),
            .o_valid (qd_valid[j+1]),
            .o_rem   (qd_rem[j+1]),
            .o_num   (qd_num[j+1]),
            .o_quo   (qd_quo[j+1]),
            .o_dvs   (qd_dvs[j+1]),
            .o_tag   (qd_tag[j+1])
        );
    end

    // ---------------- result select and saturation ----------------
    fnr_pkg::t_tag w_ft;
    logic [33:0]   w_val;
    logic          w_sat;
    fnr_pkg::t_out w_res;

    always_comb begin
        w_ft  = qd_tag[QD_N];
        w_sat = 1'b0;
        w_val = '0;
        if (w_ft.zero) begin
            w_val = 34'(fnr_pkg::ONE_FIXED);
        end else if (w_ft.big) begin
            w_val = w_ft.a >> fnr_pkg::NEG_SHIFT;
        end else if (w_ft.neg) begin
            w_val = qd_quo[QD_N] >> fnr_pkg::NEG_SHIFT;
            w_sat = w_ft.ovf;
        end else begin
            w_val = qd_quo[QD_N];
            w_sat = w_ft.ovf;
        end
        if (w_val > {9'b0, fnr_pkg::OUT_MAX}) begin
            w_sat = 1'b1;
        end
        w_res.fermi_factor = w_sat ? fnr_pkg::OUT_MAX : w_val[24:0];
        w_res.saturated    = w_sat;
    end

    // ---------------- glue stage valids ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            ru_valid <= 1'b0;
            ra_valid <= 1'b0;
            ry_valid <= 1'b0;
            rr_valid <= 1'b0;
            rg_valid <= 1'b0;
            rn_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_in_valid;
            r1_valid <= r0_valid;
            ru_valid <= rt_valid[RT_N];
            ra_valid <= ru_valid;
            ry_valid <= ra_valid;
            rr_valid <= ry_valid;
            rg_valid <= ty_valid[TY_N];
            rn_valid <= rg_valid;
        end
    end

    // ---------------- glue stage payloads ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_e   <= w_e;
            r0_tag <= w_tag0;
            r1_dd  <= w_dd;
            r1_tag <= w_tag1;
            ru_u   <= w_kq[58:32];
            ru_tag <= rt_tag[RT_N];
            ra_tag <= w_tag_a;
            ry_y   <= w_y[62:24];
            ry_tag <= w_tag_y;
            rr_r   <= w_r[63:32];
            rr_tag <= w_tag_r;
            rg_g   <= w_g;
            rg_den <= w_den;
            rg_tag <= ty_tag[TY_N];
            rn_num <= w_num;
            rn_dvs <= rg_den;
            rn_tag <= w_tag_n;
        end
    end

    // ---------------- output register and skid ----------------
    logic          r_out_valid, r_skid_valid;
    fnr_pkg::t_out r_out, r_skid;

    // Advance the pipe whenever the skid slot is free
    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= qd_valid[QD_N];
            end else if (qd_valid[QD_N]) begin
                r_skid_valid <= 1'b1;
            end
        end else if (!i_out_stall) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_valid || !i_out_stall) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (!i_out_stall) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a request while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid filled without a stalled output");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated) |-> (o_out_data.fermi_factor == fnr_pkg::OUT_MAX))
        else $error("saturated result is not the maximum code");

endmodule

// File: hw/rtl/fnr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One digit-by-digit step of an integer square root; a chain of these
// resolves one result bit per stage.
// ----------------------------------------------------------------------------
module fnr_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [63:0]   i_bit,
    input  logic          i_valid,
    input  logic [63:0]   i_rad,
    input  logic [63:0]   i_root,
    input  fnr_pkg::t_tag i_tag,
    output logic          o_valid,
    output logic [63:0]   o_rad,
    output logic [63:0]   o_root,
    output fnr_pkg::t_tag o_tag
);

    logic          r_valid;
    logic [63:0]   r_rad, n_rad;
    logic [63:0]   r_root, n_root;
    fnr_pkg::t_tag r_tag;
    logic [63:0]   w_trial;

    // Try subtracting the trial value
    always_comb begin
        w_trial = i_root + i_bit;
        if (i_rad >= w_trial) begin
            n_rad  = i_rad - w_trial;
            n_root = (i_root >> 1) + i_bit;
        end else begin
            n_rad  = i_rad;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_root <= n_root;
            r_tag  <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_root  = r_root;
    assign o_tag   = r_tag;

endmodule

// File: hw/rtl/fnr_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shift in a numerator bit, compare against
// the divisor, subtract and emit one quotient bit.
// ----------------------------------------------------------------------------
module fnr_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [33:0]   i_rem,
    input  logic [33:0]   i_num,
    input  logic [33:0]   i_quo,
    input  logic [32:0]   i_dvs,
    input  fnr_pkg::t_tag i_tag,
    output logic          o_valid,
    output logic [33:0]   o_rem,
    output logic [33:0]   o_num,
    output logic [33:0]   o_quo,
    output logic [32:0]   o_dvs,
    output fnr_pkg::t_tag o_tag
);

    logic          r_valid;
    logic [33:0]   r_rem, n_rem;
    logic [33:0]   r_num, r_quo, n_quo;
    logic [32:0]   r_dvs;
    fnr_pkg::t_tag r_tag;
    logic [34:0]   w_trial;

    // Shift in the next numerator bit and subtract when it fits
    always_comb begin
        w_trial = {i_rem, i_num[33]};
        if (w_trial >= {2'b0, i_dvs}) begin
            n_rem = 34'(w_trial - {2'b0, i_dvs});
            n_quo = {i_quo[32:0], 1'b1};
        end else begin
            n_rem = 34'(w_trial);
            n_quo = {i_quo[32:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= {i_num[32:0], 1'b0};
            r_quo <= n_quo;
            r_dvs <= i_dvs;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_dvs   = r_dvs;
    assign o_tag   = r_tag;

endmodule

// File: hw/rtl/fnr_taylor_cell.sv
// ----------------------------------------------------------------------------
// Series cell
// One term of the exp(-r) Taylor sum: term = floor(floor(term*r/2^32)/k),
// then add or subtract it. Three register stages deep.
// ----------------------------------------------------------------------------
module fnr_taylor_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [3:0]    i_k,
    input  logic [35:0]   i_recip,
    input  logic          i_odd,
    input  logic          i_valid,
    input  logic [32:0]   i_term,
    input  logic [32:0]   i_sum,
    input  logic [31:0]   i_rate,
    input  fnr_pkg::t_tag i_tag,
    output logic          o_valid,
    output logic [32:0]   o_term,
    output logic [32:0]   o_sum,
    output logic [31:0]   o_rate,
    output fnr_pkg::t_tag o_tag
);

    logic [2:0]    r_valid;
    logic [31:0]   r_a_x, r_b_x, r_b_q;
    logic [32:0]   r_a_sum, r_b_sum, r_c_sum;
    logic [31:0]   r_a_rate, r_b_rate, r_c_rate;
    fnr_pkg::t_tag r_a_tag, r_b_tag, r_c_tag;
    logic [32:0]   r_c_term;
    logic [64:0]   w_prod;
    logic [67:0]   w_scl;
    logic [35:0]   w_qk;
    logic [35:0]   w_rem;
    logic [31:0]   n_q;
    logic [32:0]   n_sum;

    // Product with the rate, then scale by the reciprocal of k
    always_comb begin
        w_prod = {32'b0, i_term} * {33'b0, i_rate};
        w_scl  = {36'b0, r_a_x} * {32'b0, i_recip};
    end

    // Fix the estimate (it is low by at most one) and update the sum
    always_comb begin
        w_qk  = {4'b0, r_b_q} * {32'b0, i_k};
        w_rem = {4'b0, r_b_x} - w_qk;
        n_q   = (w_rem >= {32'b0, i_k}) ? r_b_q + 32'd1 : r_b_q;
        n_sum = i_odd ? r_b_sum - {1'b0, n_q} : r_b_sum + {1'b0, n_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= w_prod[63:32];
            r_a_sum  <= i_sum;
            r_a_rate <= i_rate;
            r_a_tag  <= i_tag;
            r_b_x    <= r_a_x;
            r_b_q    <= w_scl[66:35];
            r_b_sum  <= r_a_sum;
            r_b_rate <= r_a_rate;
            r_b_tag  <= r_a_tag;
            r_c_term <= {1'b0, n_q};
            r_c_sum  <= n_sum;
            r_c_rate <= r_b_rate;
            r_c_tag  <= r_b_tag;
        end
    end

    assign o_valid = r_valid[2];
    assign o_term  = r_c_term;
    assign o_sum   = r_c_sum;
    assign o_rate  = r_c_rate;
    assign o_tag   = r_c_tag;

endmodule

// File: test/fermi_function_nonrel_approx_test.sv
// ----------------------------------------------------------------------------
// Fermi factor testbench
// Drives charge/energy requests with random idling on both channels, predicts in
// fixed point each Fermi factor that the table does not give, checks results in order.
// ----------------------------------------------------------------------------
module fermi_function_nonrel_approx_test;

    localparam int LATENCY   = 146;
    localparam int MAX_ERRS  = 10;
    localparam longint LIMIT = 2000000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    fnr_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    fnr_pkg::t_out o_out_data;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [18:0]   i_cfg_data;

    fermi_function_nonrel_approx u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state and checking store
    logic [18:0]   mass_ev;
    fnr_pkg::t_out factor_q[$];
    int            mismatches;
    int            checked;
    int            saturations;
    longint        cycles;
    bit            calm;

    // Directed table: expected only where obvious
    typedef struct {
        logic signed [7:0] z;
        logic [24:0]       e;
        bit                known;
        fnr_pkg::t_out     want;
    } t_row;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] exp_neg(input logic [63:0] a);
        logic [63:0] y, n, fr, r, term, sum;
        logic [127:0] wide;
        if (a >= 64'd1 << 30) return 0;
        wide = 128'(a) * 128'(fnr_pkg::L2E);
        y    = 64'(wide >> 24);
        n    = y >> 32;
        if (n >= 32) return 0;
        fr   = y & 64'hFFFF_FFFF;
        r    = (fr * 64'(fnr_pkg::LN2)) >> 32;
        term = 64'(fnr_pkg::ONE_Q32);
        sum  = 64'(fnr_pkg::ONE_Q32);
        for (int k = 1; k <= fnr_pkg::TAYLOR_TERMS; k++) begin
            term = ((term * r) >> 32) / k;
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        return sum >> n;
    endfunction

    function automatic fnr_pkg::t_out fermi_predict(input fnr_pkg::t_in req,
                                                    input logic [18:0] me_in);
        logic [63:0] zmag, e, me, dd, s, ratio, u, a, g, d;
        logic [127:0] f;
        fnr_pkg::t_out res;
        zmag = req.charge_number[7] ? 64'(256 - int'(req.charge_number[7:0]))
                                    : 64'(req.charge_number[7:0]);
        e  = 64'(req.kinetic_energy_ev);
        me = 64'(me_in);
        if (e < 50) e = 50;
        if (zmag == 0) begin
            f = 128'(1) << fnr_pkg::FRACTION_BITS;
        end else begin
            dd    = e * (e + 2 * me);
            s     = int_sqrt(dd << 12);
            ratio = ((me + e) << 30) / s;
            u     = 64'((128'(fnr_pkg::KQ) * 128'(ratio)) >> 32);
            a     = zmag * u;
            g     = exp_neg(a);
            d     = 64'(fnr_pkg::ONE_Q32) - g;
            if (d == 0) d = 1;
            if (!req.charge_number[7]) begin
                if (a >= 64'd1 << 30) f = 128'(a >> fnr_pkg::NEG_SHIFT);
                else f = (128'(a) << fnr_pkg::POS_SHIFT) / 128'(d);
            end else begin
                f = ((128'(a) * 128'(g)) / 128'(d)) >> fnr_pkg::NEG_SHIFT;
            end
        end
        res.saturated    = f > 128'(fnr_pkg::OUT_MAX);
        res.fermi_factor = res.saturated ? fnr_pkg::OUT_MAX : f[24:0];
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Count cycles, stop on timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result stall in random bursts
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare accepted results with the oldest prediction
    always @(posedge i_clk) begin
        fnr_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (factor_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_ERRS) $display("unexpected result %h", o_out_data);
            end else begin
                want = factor_q.pop_front();
                checked++;
                if (o_out_data.saturated) saturations++;
                if (o_out_data.fermi_factor !== want.fermi_factor ||
                    o_out_data.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= MAX_ERRS)
                        $display("mismatch: expected F=%h sat=%b, got F=%h sat=%b",
                                 want.fermi_factor, want.saturated,
                                 o_out_data.fermi_factor, o_out_data.saturated);
                end
            end
        end
    end

    // Send one request, idling first at random
    task automatic send_request(input fnr_pkg::t_in req, input bit has_want,
                                input fnr_pkg::t_out want);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        factor_q.push_back(has_want ? want : fermi_predict(req, mass_ev));
    endtask

    // Wait for every result, then let the pipe drain
    task automatic drain_all();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (factor_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_mass(input logic [18:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mass_ev = value;
    endtask

    function automatic fnr_pkg::t_in rand_request();
        fnr_pkg::t_in req;
        req.charge_number = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       req.kinetic_energy_ev = 25'($urandom_range(0, 100));
            1:       req.kinetic_energy_ev = 25'($urandom_range(0, 65535));
            2:       req.kinetic_energy_ev = 25'($urandom_range(0, 4000000));
            default: req.kinetic_energy_ev = 25'($urandom);
        endcase
        return req;
    endfunction

    initial begin
        t_row          rows[$];
        fnr_pkg::t_in  req;
        fnr_pkg::t_out none;
        logic [18:0]   masses[6];
        none        = '0;
        mismatches  = 0;
        checked     = 0;
        saturations = 0;
        cycles      = 0;
        calm        = 1'b0;
        mass_ev     = fnr_pkg::MASS_RESET;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero charge gives exactly one, at any energy
        rows.push_back('{8'sd0, 25'd0, 1, '{fnr_pkg::ONE_FIXED, 1'b0}});
        rows.push_back('{8'sd0, 25'h1FF_FFFF, 1, '{fnr_pkg::ONE_FIXED, 1'b0}});
        rows.push_back('{8'sd0, 25'd50, 1, '{fnr_pkg::ONE_FIXED, 1'b0}});
        // Low energy clamp, extremes of charge, the -128 pattern
        rows.push_back('{8'sd1, 25'd0, 0, none});
        rows.push_back('{8'sd1, 25'd49, 0, none});
        rows.push_back('{8'sd1, 25'd50, 0, none});
        rows.push_back('{8'sd127, 25'd0, 0, none});
        rows.push_back('{8'sd127, 25'h1FF_FFFF, 0, none});
        rows.push_back('{-8'sd1, 25'd0, 0, none});
        rows.push_back('{-8'sd127, 25'd0, 0, none});
        rows.push_back('{-8'sd128, 25'd0, 0, none});
        rows.push_back('{-8'sd128, 25'h1FF_FFFF, 0, none});
        rows.push_back('{8'sd1, 25'h1FF_FFFF, 0, none});
        rows.push_back('{-8'sd1, 25'h1FF_FFFF, 0, none});
        rows.push_back('{8'sd82, 25'd1000, 0, none});
        rows.push_back('{-8'sd82, 25'd1000000, 0, none});
        rows.push_back('{8'sh55, 25'h0AA_AAAA, 0, none});
        rows.push_back('{-8'sd43, 25'h155_5555, 0, none});
        foreach (rows[i]) begin
            req.charge_number     = rows[i].z;
            req.kinetic_energy_ev = rows[i].e;
            send_request(req, rows[i].known, rows[i].want);
        end
        // Hold off until everything has come back
        drain_all();

        // Random phases across several mass settings, extremes included
        masses = '{19'd0, 19'h7FFFF, 19'd500000, 19'd520000, 19'd1, fnr_pkg::MASS_RESET};
        foreach (masses[m]) begin
            write_mass(masses[m]);
            repeat (masses[m] == fnr_pkg::MASS_RESET ? 400 : 300) begin
                if (m == 5) calm = 1'b1;
                send_request(rand_request(), 0, none);
            end
            drain_all();
        end

        $display("%0d results checked over 6 mass settings, %0d saturated, %0d mismatches",
                 checked, saturations, mismatches);
        if (mismatches == 0 && factor_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: fermi_function_nonrel_approx.f
hw/rtl/fnr_pkg.sv
hw/rtl/fnr_sqrt_cell.sv
hw/rtl/fnr_div_cell.sv
hw/rtl/fnr_taylor_cell.sv
hw/rtl/fermi_function_nonrel_approx.sv
test/fermi_function_nonrel_approx_test.sv
